@@ hw/rtl/dspp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspp_pkg
// Shared types and opcodes of the dual stepper position pulser.
// ----------------------------------------------------------------------------
package dspp_pkg;

	localparam int unsigned PosW = 16;
	localparam int unsigned PerW = 16;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_RUN    = 3'd1,
		OP_SET    = 3'd2,
		OP_STOP   = 3'd3,
		OP_ADJUST = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	typedef struct packed {
		logic [PosW-1:0] position;
		logic [PosW-1:0] goal;
		logic [PerW-1:0] reload;
		logic [PerW-1:0] countdown;
		logic            pulse_high;
		logic            finished;
		logic            dir_level;
		logic            driver_awake;
	} motor_state_t;

	typedef struct packed {
		logic            tick;
		logic            sel;
		logic [2:0]      opcode;
		logic [PosW-1:0] target;
		logic [PerW-1:0] period;
		logic [PosW-1:0] delta;
	} motor_cmd_t;

	localparam motor_state_t MotorReset = '{
		position:     '0,
		goal:         '0,
		reload:       '0,
		countdown:    '0,
		pulse_high:   1'b0,
		finished:     1'b1,
		dir_level:    1'b1,
		driver_awake: 1'b0
	};

endpackage

@@ hw/rtl/dspp_cmd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspp_cmd_if
// Request channel: one opcode with its operands per request.
// ----------------------------------------------------------------------------
interface dspp_cmd_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  opcode;
	logic               motor;
	logic signed [15:0] target;
	logic        [15:0] period;
	logic signed [15:0] delta;

	modport source (output valid, opcode, motor, target, period, delta, input ready);
	modport sink (input valid, opcode, motor, target, period, delta, output ready);
endinterface

@@ hw/rtl/dspp_res_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspp_res_if
// Result channel: pin levels and positions of both motors.
// ----------------------------------------------------------------------------
interface dspp_res_if;
	logic               valid;
	logic               ready;
	logic               step_pin_a;
	logic               step_pin_b;
	logic               dir_pin_a;
	logic               dir_pin_b;
	logic               awake_a;
	logic               awake_b;
	logic               done_a;
	logic               done_b;
	logic signed [15:0] position_a;
	logic signed [15:0] position_b;

	modport source (
		output valid, step_pin_a, step_pin_b, dir_pin_a, dir_pin_b, awake_a, awake_b,
		       done_a, done_b, position_a, position_b,
		input  ready
	);
	modport sink (
		input  valid, step_pin_a, step_pin_b, dir_pin_a, dir_pin_b, awake_a, awake_b,
		       done_a, done_b, position_a, position_b,
		output ready
	);
endinterface

@@ hw/rtl/dual_stepper_position_pulser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stepper_position_pulser_top
// Step/direction generator for two stepper motors driven by an opcode stream.
// ----------------------------------------------------------------------------
// The result of an accepted request is in the output register in the next cycle.
// Throughput: one request per cycle when not stalled; both updates are single-pass.
// A request is taken whenever the output register is empty or being drained.
// Reset: positions, goals and periods clear, both motors done and asleep,
// direction pins high, output register empty.
module dual_stepper_position_pulser_top
	import dspp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	dspp_cmd_if.sink      cmd,
	dspp_res_if.source    res
);

	motor_state_t st_q  [2];
	motor_state_t st_nx [2];
	motor_cmd_t   mcmd  [2];
	logic         valid_s1;
	logic         accept;

	assign cmd.ready = !valid_s1 || res.ready;
	assign accept    = cmd.valid && cmd.ready;

	for (genvar m = 0; m < 2; m++) begin : g_motor
		always_comb begin
			mcmd[m].tick   = (cmd.opcode == OP_TICK);
			mcmd[m].sel    = (cmd.motor == 1'(m));
			mcmd[m].opcode = cmd.opcode;
			mcmd[m].target = cmd.target;
			mcmd[m].period = cmd.period;
			mcmd[m].delta  = cmd.delta;
		end

		dspp_motor u_motor (
			.cur    (st_q[m]),
			.cmd    (mcmd[m]),
			.dir_up (m == 0 ? 1'b1 : 1'b0),
			.nxt    (st_nx[m])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				st_q[m] <= MotorReset;
			end else if (accept) begin
				st_q[m] <= st_nx[m];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (res.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// result payload: shown straight from the committed motor state
	assign res.valid      = valid_s1;
	assign res.step_pin_a = st_q[0].pulse_high;
	assign res.step_pin_b = st_q[1].pulse_high;
	assign res.dir_pin_a  = st_q[0].dir_level;
	assign res.dir_pin_b  = st_q[1].dir_level;
	assign res.awake_a    = st_q[0].driver_awake;
	assign res.awake_b    = st_q[1].driver_awake;
	assign res.done_a     = st_q[0].finished;
	assign res.done_b     = st_q[1].finished;
	assign res.position_a = $signed(st_q[0].position);
	assign res.position_b = $signed(st_q[1].position);

endmodule

@@ hw/rtl/dspp_motor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspp_motor
// Next-state logic of one motor: countdown, step pulse and command update.
// ----------------------------------------------------------------------------
module dspp_motor
	import dspp_pkg::*;
(
	input  motor_state_t cur,
	input  motor_cmd_t   cmd,
	input  logic         dir_up,
	output motor_state_t nxt
);

	logic [PerW-1:0] cd_dec;

	always_comb begin
		nxt    = cur;
		cd_dec = (cur.countdown != '0) ? cur.countdown - PerW'(1) : '0;
		if (cmd.tick) begin
			if (!cur.finished) begin
				if (cd_dec != '0) begin
					nxt.countdown = cd_dec;
				end else begin
					nxt.countdown = cur.reload;
					if (cur.pulse_high) begin
						nxt.pulse_high = 1'b0;
					end else if ($signed(cur.position) < $signed(cur.goal)) begin
						nxt.dir_level  = dir_up;
						nxt.position   = cur.position + PosW'(1);
						nxt.pulse_high = 1'b1;
					end else if ($signed(cur.position) > $signed(cur.goal)) begin
						nxt.dir_level  = ~dir_up;
						nxt.position   = cur.position - PosW'(1);
						nxt.pulse_high = 1'b1;
					end else begin
						nxt.finished     = 1'b1;
						nxt.driver_awake = 1'b0;
					end
				end
			end
		end else if (cmd.sel) begin
			case (cmd.opcode)
				OP_RUN: begin
					nxt.goal         = cmd.target;
					nxt.reload       = cmd.period;
					nxt.finished     = 1'b0;
					nxt.driver_awake = 1'b1;
				end
				OP_SET: begin
					nxt.goal   = cmd.target;
					nxt.reload = cmd.period;
				end
				OP_STOP: begin
					nxt.finished     = 1'b1;
					nxt.driver_awake = 1'b0;
				end
				OP_ADJUST: nxt.position = cur.position + cmd.delta;
				OP_CLEAR:  nxt.position = '0;
				default:   nxt = cur;
			endcase
		end
	end

endmodule

@@ hw/rtl/dspp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspp_checker
// Port-level checks of the dual stepper position pulser.
// ----------------------------------------------------------------------------
module dspp_checker (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic res_valid,
	input logic res_ready,
	input logic done_a,
	input logic done_b,
	input logic awake_a,
	input logic awake_b
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> cmd_ready)
		else $error("request refused with empty output");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> res_valid)
		else $error("accepted request produced no result");

	a_done_sleep: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (done_a != awake_a) && (done_b != awake_b))
		else $error("done and awake out of step");

endmodule

bind dual_stepper_position_pulser_top dspp_checker u_dspp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.done_a    (res.done_a),
	.done_b    (res.done_b),
	.awake_a   (res.awake_a),
	.awake_b   (res.awake_b)
);
